[rtl/spring_force_vector_assert.svh]
// ============================================================================
// spring_force_vector assertion macros
// Shorthand for clocked implication checks used inside the block.
// ============================================================================
`ifndef SPRING_FORCE_VECTOR_ASSERT_SVH
`define SPRING_FORCE_VECTOR_ASSERT_SVH

// same-cycle implication
`define SFV_ASSERT_IMPLY(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("spring_force_vector: same-cycle check failed");

// next-cycle implication
`define SFV_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("spring_force_vector: next-cycle check failed");

`endif

[rtl/sfv_pkg.sv]
// ============================================================================
// sfv_pkg
// Fixed constants of the spring force block: register port and widths.
// ============================================================================
package sfv_pkg;

	// spring constant is unsigned Q16.16, rest length is 31 bits
	localparam int K_BITS        = 32;
	localparam int REST_BITS     = 31;

	// configuration port
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [CFG_IDX_BITS-1:0] CFG_SPRING_K    = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_REST_LENGTH = 1'b1;

	// 1.0 in Q16.16
	localparam logic [K_BITS-1:0] K_RESET = 32'h0001_0000;

endpackage

[rtl/sfv_in_if.sv]
// ============================================================================
// sfv_in_if
// Input channel: mode and the two positions, valid/ready handshake.
// ============================================================================
interface sfv_in_if #(
	parameter int COORD_BITS = 32
);
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic signed [COORD_BITS-1:0] self_x;
	logic signed [COORD_BITS-1:0] self_y;
	logic signed [COORD_BITS-1:0] self_z;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic signed [COORD_BITS-1:0] end_z;

	modport source (
		output valid, mode, self_x, self_y, self_z, end_x, end_y, end_z,
		input  ready
	);
	modport sink (
		input  valid, mode, self_x, self_y, self_z, end_x, end_y, end_z,
		output ready
	);
endinterface

[rtl/sfv_out_if.sv]
// ============================================================================
// sfv_out_if
// Output channel: saturated force vector and clip flag, valid/ready handshake.
// ============================================================================
interface sfv_out_if #(
	parameter int COORD_BITS = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] force_x;
	logic signed [COORD_BITS-1:0] force_y;
	logic signed [COORD_BITS-1:0] force_z;
	logic                         clipped;

	modport source (
		output valid, force_x, force_y, force_z, clipped,
		input  ready
	);
	modport sink (
		input  valid, force_x, force_y, force_z, clipped,
		output ready
	);
endinterface

[rtl/spring_force_vector.sv]
// ============================================================================
// spring_force_vector
// Hooke's-law spring force on a particle, fully pipelined.
// ============================================================================
// One item enters per clock and one force item leaves per clock while the
// output item is taken. The pipe registers difference, squares and sum, then
// the one-bit-per-stage square root, then extension, magnitude, the split
// product and its join, then the one-bit-per-stage divider lanes, and the
// output register. The whole pipe advances together and holds when the output
// item is not taken.
`include "spring_force_vector_assert.svh"

module spring_force_vector #(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sfv_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [sfv_pkg::CFG_DATA_BITS-1:0] cfg_data,
	sfv_in_if.sink                           in_ch,
	sfv_out_if.source                        out_ch
);

	localparam int C   = COORD_BITS;
	localparam int LW  = C + 1;                     // difference / length width
	localparam int SW  = 2 * LW;                    // squared length width
	localparam int EW  = (LW > sfv_pkg::REST_BITS) ? LW : sfv_pkg::REST_BITS;
	localparam int EPW = EW + sfv_pkg::K_BITS;      // extension * k
	localparam int MW  = EPW - FRAC_BITS;           // magnitude width
	localparam int NW  = MW + LW;                   // magnitude * |d|
	localparam int HL  = MW / 2;
	localparam int HH  = MW - HL;
	localparam int PL  = HL + LW;
	localparam int PH  = HH + LW;

	localparam logic [C-1:0] POS_LIM = {1'b0, {(C-1){1'b1}}};
	localparam logic [C-1:0] NEG_LIM = {1'b1, {(C-1){1'b0}}};

	typedef struct packed {
		logic               mode;
		logic [2:0]         dneg;
		logic [2:0][LW-1:0] dabs;
	} sd_t;

	typedef struct packed {
		logic [LW-1:0] len;
		logic          zero;
		logic          eneg;
		logic [2:0]    dneg;
		logic [2:0]    ovf;
	} dv_t;

	// configuration registers
	logic [sfv_pkg::K_BITS-1:0]    k_q;
	logic [sfv_pkg::REST_BITS-1:0] rest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= sfv_pkg::K_RESET;
			rest_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				sfv_pkg::CFG_SPRING_K:    k_q    <= cfg_data[sfv_pkg::K_BITS-1:0];
				sfv_pkg::CFG_REST_LENGTH: rest_q <= cfg_data[sfv_pkg::REST_BITS-1:0];
				default: ;
			endcase
		end
	end

	// global advance: whole pipe moves unless the output item is stuck
	logic out_vld_q;
	logic adv;
	assign adv         = !out_vld_q || out_ch.ready;
	assign in_ch.ready = adv;

	// ---- stage 1: differences and their magnitudes
	logic [2:0][C-1:0] sp, ep;
	sd_t               sd_d1;
	logic              vld_s1;
	sd_t               sd_s1;

	assign sp = {in_ch.self_z, in_ch.self_y, in_ch.self_x};
	assign ep = {in_ch.end_z, in_ch.end_y, in_ch.end_x};

	always_comb begin
		logic [LW-1:0] d;
		sd_d1.mode = in_ch.mode;
		for (int i = 0; i < 3; i++) begin
			d              = {sp[i][C-1], sp[i]} - {ep[i][C-1], ep[i]};
			sd_d1.dneg[i]  = d[LW-1];
			sd_d1.dabs[i]  = d[LW-1] ? (~d + 1'b1) : d;
		end
	end

	// ---- stage 2: squares
	logic              vld_s2;
	sd_t               sd_s2;
	logic [2:0][SW-1:0] sqr_s2;

	// ---- stage 3: sum of squares
	logic              vld_s3;
	sd_t               sd_s3;
	logic [SW-1:0]     sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_ch.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s1 <= sd_d1;
			sd_s2 <= sd_s1;
			for (int i = 0; i < 3; i++) begin
				sqr_s2[i] <= SW'(sd_s1.dabs[i]) * SW'(sd_s1.dabs[i]);
			end
			sd_s3  <= sd_s2;
			sum_s3 <= sqr_s2[0] + sqr_s2[1] + sqr_s2[2];
		end
	end

	// ---- square root: one result bit per stage
	logic [SW-1:0] rt_rad_s  [LW+1];
	logic [LW+1:0] rt_rem_s  [LW+1];
	logic [LW-1:0] rt_root_s [LW+1];
	sd_t           rt_sd_s   [LW+1];
	logic          rt_vld_s  [LW+1];

	assign rt_rad_s[0]  = sum_s3;
	assign rt_rem_s[0]  = '0;
	assign rt_root_s[0] = '0;
	assign rt_sd_s[0]   = sd_s3;
	assign rt_vld_s[0]  = vld_s3;

	for (genvar j = 0; j < LW; j++) begin : g_sqrt
		logic [LW+1:0] rem_sh, trial;
		logic          ge;

		always_comb begin
			rem_sh = {rt_rem_s[j][LW-1:0], rt_rad_s[j][SW-1 -: 2]};
			trial  = {rt_root_s[j], 2'b01};
			ge     = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[j+1] <= 1'b0;
			end else if (adv) begin
				rt_vld_s[j+1] <= rt_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_rad_s[j+1]  <= {rt_rad_s[j][SW-3:0], 2'b00};
				rt_rem_s[j+1]  <= ge ? (rem_sh - trial) : rem_sh;
				rt_root_s[j+1] <= {rt_root_s[j][LW-2:0], ge};
				rt_sd_s[j+1]   <= rt_sd_s[j];
			end
		end
	end

	// ---- stage 4: extension against rest length
	logic [EW-1:0] len_x, rest_x, eabs_d4;
	logic          eneg_raw;

	always_comb begin
		len_x    = EW'(rt_root_s[LW]);
		rest_x   = EW'(rest_q);
		eneg_raw = len_x < rest_x;
		eabs_d4  = eneg_raw ? (rest_x - len_x) : (len_x - rest_x);
	end

	logic          vld_s4, vld_s5, vld_s6, vld_s7;
	sd_t           sd_s4, sd_s5, sd_s6;
	logic [LW-1:0] len_s4, len_s5, len_s6, len_s7;
	logic          eneg_s4, eneg_s5, eneg_s6, eneg_s7;
	logic [EW-1:0] eabs_s4;
	logic [MW-1:0] mag_s5;
	logic [2:0][PL-1:0] pl_s6;
	logic [2:0][PH-1:0] ph_s6;
	logic [2:0]         dneg_s7, ovf_s7;
	logic [2:0][LW-1:0] rem_s7;
	logic [2:0][C-1:0]  num_s7;

	// ---- stage 5 input: magnitude = extension * k, Q shift
	logic [EPW-1:0] prod_d5;
	assign prod_d5 = EPW'(eabs_s4) * EPW'(k_q);

	// ---- stage 7 input: join partial products, check quotient range
	logic [2:0][NW-1:0] num_d7;
	logic [2:0]         ovf_d7;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_d7[i] = {ph_s6[i], {HL{1'b0}}} + NW'(pl_s6[i]);
			ovf_d7[i] = num_d7[i][NW-1:C] >= (NW-C)'(len_s6);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= rt_vld_s[LW];
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s4   <= rt_sd_s[LW];
			len_s4  <= rt_root_s[LW];
			eabs_s4 <= eabs_d4;
			eneg_s4 <= eneg_raw && !rt_sd_s[LW].mode;

			sd_s5   <= sd_s4;
			len_s5  <= len_s4;
			eneg_s5 <= eneg_s4;
			mag_s5  <= prod_d5[EPW-1:FRAC_BITS];

			sd_s6   <= sd_s5;
			len_s6  <= len_s5;
			eneg_s6 <= eneg_s5;
			for (int i = 0; i < 3; i++) begin
				pl_s6[i] <= PL'(mag_s5[HL-1:0]) * PL'(sd_s5.dabs[i]);
				ph_s6[i] <= PH'(mag_s5[MW-1:HL]) * PH'(sd_s5.dabs[i]);
			end

			len_s7  <= len_s6;
			eneg_s7 <= eneg_s6;
			dneg_s7 <= sd_s6.dneg;
			ovf_s7  <= ovf_d7;
			for (int i = 0; i < 3; i++) begin
				rem_s7[i] <= num_d7[i][C+LW-1:C];
				num_s7[i] <= num_d7[i][C-1:0];
			end
		end
	end

	// ---- divider lanes: one quotient bit per stage
	logic [2:0][LW-1:0] dv_rem_s [C+1];
	logic [2:0][C-1:0]  dv_num_s [C+1];
	logic [2:0][C-1:0]  dv_q_s   [C+1];
	dv_t                dv_sd_s  [C+1];
	logic               dv_vld_s [C+1];

	assign dv_rem_s[0]     = rem_s7;
	assign dv_num_s[0]     = num_s7;
	assign dv_q_s[0]       = '0;
	assign dv_sd_s[0].len  = len_s7;
	assign dv_sd_s[0].zero = (len_s7 == '0);
	assign dv_sd_s[0].eneg = eneg_s7;
	assign dv_sd_s[0].dneg = dneg_s7;
	assign dv_sd_s[0].ovf  = ovf_s7;
	assign dv_vld_s[0]     = vld_s7;

	for (genvar k = 0; k < C; k++) begin : g_div
		logic [2:0][LW-1:0] rem_n;
		logic [2:0]         qb;

		always_comb begin
			logic [LW:0] rs, df;
			for (int i = 0; i < 3; i++) begin
				rs       = {dv_rem_s[k][i], dv_num_s[k][i][C-1]};
				df       = rs - {1'b0, dv_sd_s[k].len};
				qb[i]    = rs >= {1'b0, dv_sd_s[k].len};
				rem_n[i] = qb[i] ? df[LW-1:0] : rs[LW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_sd_s[k+1] <= dv_sd_s[k];
				for (int i = 0; i < 3; i++) begin
					dv_rem_s[k+1][i] <= rem_n[i];
					dv_num_s[k+1][i] <= {dv_num_s[k][i][C-2:0], 1'b0};
					dv_q_s[k+1][i]   <= {dv_q_s[k][i][C-2:0], qb[i]};
				end
			end
		end
	end

	// ---- sign and saturation
	logic [2:0][C-1:0] frc_d;
	logic              clip_d;

	always_comb begin
		logic          neg;
		logic [C-1:0]  lim, v;
		clip_d = 1'b0;
		for (int i = 0; i < 3; i++) begin
			neg = (dv_sd_s[C].eneg == dv_sd_s[C].dneg[i]);
			lim = neg ? NEG_LIM : POS_LIM;
			v   = dv_q_s[C][i];
			if (dv_sd_s[C].ovf[i] || (dv_q_s[C][i] > lim)) begin
				v      = lim;
				clip_d = 1'b1;
			end
			frc_d[i] = neg ? ('0 - v) : v;
		end
		if (dv_sd_s[C].zero) begin
			frc_d  = '0;
			clip_d = 1'b0;
		end
	end

	// ---- output register
	logic [2:0][C-1:0] frc_q;
	logic              clip_q;
	logic              zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= dv_vld_s[C];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frc_q  <= frc_d;
			clip_q <= clip_d;
			zero_q <= dv_sd_s[C].zero;
		end
	end

	assign out_ch.valid   = out_vld_q;
	assign out_ch.force_x = frc_q[0];
	assign out_ch.force_y = frc_q[1];
	assign out_ch.force_z = frc_q[2];
	assign out_ch.clipped = clip_q;

	// ---- checks
	`SFV_ASSERT_IMPLY(a_zero_len_no_force, out_vld_q && zero_q, (frc_q == '0) && !clip_q)
	`SFV_ASSERT_IMPLY(a_clip_at_limit, out_vld_q && clip_q, (frc_q[0] == POS_LIM) || (frc_q[0] == NEG_LIM) || (frc_q[1] == POS_LIM) || (frc_q[1] == NEG_LIM) || (frc_q[2] == POS_LIM) || (frc_q[2] == NEG_LIM))
	`SFV_ASSERT_NEXT(a_stall_freeze, !adv, $stable(vld_s4) && $stable(vld_s7) && $stable(out_vld_q))

endmodule
